FILE: rtl/bstp_pkg.sv
// ----------------------------------------------------------------------------
// bstp_pkg: shared types and helpers for the skeleton thinning pass
// Pixel classes, configuration codes, item structs and the erosion rule.
// ----------------------------------------------------------------------------
package bstp_pkg;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int PR_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [FH_W-1:0] HEIGHT_LIMIT = 13'd4096;
  localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd1024;

  // neighbour codes with a fixed answer
  localparam logic [7:0] CODE_ERODE_A = 8'd54;
  localparam logic [7:0] CODE_ERODE_B = 8'd216;
  localparam logic [7:0] CODE_KEEP_A  = 8'd99;
  localparam logic [7:0] CODE_KEEP_B  = 8'd141;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_PRUNE_LEVEL  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_OFF    = 2'd0,
    CLS_ERODED = 2'd1,
    CLS_ON     = 2'd2
  } cls_e;

  typedef struct packed {
    logic [FW_W-1:0] width;
    logic [FH_W-1:0] height;
    logic [PR_W-1:0] prune;
  } cfg_t;

  typedef struct packed {
    logic             emit;
    logic [PIX_W-1:0] value;
  } op_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_value;
    logic             end_of_row;
    logic             end_of_frame;
  } res_t;

  localparam int OP_W  = $bits(op_t);
  localparam int RES_W = $bits(res_t);

  function automatic cls_e class_of(input logic [PIX_W-1:0] v);
    cls_e c;
    if (v == '0) begin
      c = CLS_OFF;
    end else if (v == PIX_W'(1)) begin
      c = CLS_ERODED;
    end else begin
      c = CLS_ON;
    end
    return c;
  endfunction

  // a: neighbour nonzero, b: neighbour on; bit 0 left, then clockwise
  function automatic logic erodes(input logic [7:0] a, input logic [7:0] b,
                                  input logic [PR_W-1:0] prune);
    logic [2:0] faces;
    logic [2:0] corners;
    logic [3:0] total;
    logic       full;
    logic       e;
    logic       e_late;
    logic       ring;
    logic       trip;
    logic       stop_a;
    logic       stop_b;
    logic       stop_c;
    logic       stop_d;
    logic       res;
    faces   = 3'(a[0]) + 3'(a[2]) + 3'(a[4]) + 3'(a[6]);
    corners = 3'(a[1]) + 3'(a[3]) + 3'(a[5]) + 3'(a[7]);
    total   = 4'(faces) + 4'(corners);
    full    = prune > 2'd1;
    e = (faces == 3'd2 && corners == 3'd0 && a[2] && a[4]) || (full && total <= 4'd1);
    // any run of three set neighbours followed by a clear one breaks the ring
    ring = 1'b1;
    for (int j = 0; j < 8; j++) begin
      if (a[3'(j)] && a[3'(j + 1)] && a[3'(j + 2)] && !a[3'(j + 3)]) ring = 1'b0;
    end
    trip = (a[1] && a[2] && a[3]) || (a[3] && a[4] && a[5]) ||
           (a[5] && a[6] && a[7]) || (a[7] && a[0] && a[1]);
    stop_a = !full && faces == 3'd1 && corners == 3'd2 && trip;
    stop_b = prune == 2'd0 && faces == 3'd2 && corners == 3'd2 && !ring;
    stop_c = !((!a[1] || b[0] || b[2]) && (!a[3] || b[2] || b[4]) &&
               (!a[5] || b[4] || b[6]) && (!a[7] || b[6] || b[0]));
    stop_d = !((!a[0] || !a[4] || b[2] || b[6]) && (!a[2] || !a[6] || b[0] || b[4]));
    e_late = e || full || faces > 3'd2 || (faces == 3'd2 && corners > 3'd1);
    if (a == CODE_ERODE_A || a == CODE_ERODE_B) begin
      res = 1'b1;
    end else if (a == CODE_KEEP_A || a == CODE_KEEP_B) begin
      res = 1'b0;
    end else if ((a[0] && a[2] && a[4] && a[6]) || stop_a || stop_b || stop_c || stop_d) begin
      res = e;
    end else begin
      res = e_late;
    end
    return res;
  endfunction

endpackage

FILE: rtl/bstp_if.sv
// ----------------------------------------------------------------------------
// bstp_if: stream channels of the thinning pass
// Pixel input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bstp_in_if import bstp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output mode, output pixel_value, input ready);
  modport sink   (input valid, input mode, input pixel_value, output ready);
endinterface

interface bstp_out_if import bstp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_value;
  logic             end_of_row;
  logic             end_of_frame;

  modport source (output valid, output out_value, output end_of_row,
                  output end_of_frame, input ready);
  modport sink   (input valid, input out_value, input end_of_row,
                  input end_of_frame, output ready);
endinterface

FILE: rtl/bstp_fifo.sv
// ----------------------------------------------------------------------------
// bstp_fifo: small flop-based queue
// First-word-fall-through queue with an occupancy count.
// ----------------------------------------------------------------------------
module bstp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_valid_i,
  input  logic [W-1:0]             push_data_i,
  output logic                     push_ready_o,
  output logic                     pop_valid_o,
  output logic [W-1:0]             pop_data_o,
  input  logic                     pop_ready_i,
  output logic [$clog2(DEPTH):0]   count_o
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wptr_q;
  logic [AW-1:0] rptr_q;
  logic [AW:0]   cnt_q;
  logic          push;
  logic          pop;

  assign push_ready_o = cnt_q != (AW+1)'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rptr_q];
  assign count_o      = cnt_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  // store a beat
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

FILE: rtl/bstp_front.sv
// ----------------------------------------------------------------------------
// bstp_front: item intake and classification
// Tracks the arrival position and drain phase, drops ignored items and
// queues a window shift per kept beat, marked when it produces a result.
// ----------------------------------------------------------------------------
module bstp_front import bstp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       restart_i,
  bstp_in_if.sink    pix_i,
  output op_t        op_o,
  output logic       op_valid_o,
  input  logic       op_ready_i
);
  logic [FW_W-1:0] ac_q, ac_d;
  logic [FH_W-2:0] ar_q, ar_d;
  logic [FW_W:0]   drain_q, drain_d;
  logic            accept;
  logic            draining;
  logic            col_last;
  logic            row_last;

  assign pix_i.ready = op_ready_i;
  assign accept      = pix_i.valid && op_ready_i;
  assign draining    = drain_q != '0;
  assign col_last    = (ac_q + 11'd1) >= cfg_i.width;
  assign row_last    = ({1'b0, ar_q} + 13'd1) >= cfg_i.height;

  // classify the beat and advance positions
  always_comb begin
    ac_d       = ac_q;
    ar_d       = ar_q;
    drain_d    = drain_q;
    op_valid_o = 1'b0;
    op_o.emit  = 1'b0;
    op_o.value = pix_i.pixel_value;
    if (accept) begin
      if (pix_i.mode) begin
        if (draining) begin
          op_valid_o = 1'b1;
          op_o.emit  = 1'b1;
          op_o.value = '0;
          drain_d    = drain_q - 1'b1;
        end
      end else if (!draining) begin
        op_valid_o = 1'b1;
        op_o.emit  = (ar_q >= 12'd2) || (ar_q == 12'd1 && ac_q != '0);
        if (col_last) begin
          ac_d = '0;
          if (row_last) begin
            ar_d    = '0;
            drain_d = (cfg_i.height >= 13'd2) ? ({1'b0, cfg_i.width} + 12'd1)
                                              : {1'b0, cfg_i.width};
          end else begin
            ar_d = ar_q + 1'b1;
          end
        end else begin
          ac_d = ac_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac_q    <= '0;
      ar_q    <= '0;
      drain_q <= '0;
    end else if (restart_i) begin
      ac_q    <= '0;
      ar_q    <= '0;
      drain_q <= '0;
    end else begin
      ac_q    <= ac_d;
      ar_q    <= ar_d;
      drain_q <= drain_d;
    end
  end

endmodule

FILE: rtl/bstp_back.sv
// ----------------------------------------------------------------------------
// bstp_back: 3x3 window engine
// Line memories for raw values and processed classes, a two-stage window
// pipeline and an output queue; issue is held while the queue could overflow.
// ----------------------------------------------------------------------------
module bstp_back import bstp_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       restart_i,
  input  op_t        op_i,
  input  logic       op_valid_i,
  output logic       op_ready_o,
  bstp_out_if.source res_o
);
  localparam int AW        = $clog2(MAX_WIDTH);
  localparam int OUT_DEPTH = 4;
  localparam int OCW       = $clog2(OUT_DEPTH) + 1;

  // line memories
  logic [PIX_W-1:0] raw_mem [MAX_WIDTH];
  cls_e             cls_mem [MAX_WIDTH];

  // issue-stage counters
  logic [FW_W-1:0]  pcol_q;
  logic [FW_W-1:0]  ecol_q;
  logic [FH_W-2:0]  erow_q;
  logic             issue;
  logic             e_l, e_r, e_u, e_d;

  // window-stage registers
  logic             s1_valid_q;
  logic             s1_emit_q;
  logic [PIX_W-1:0] s1_value_q;
  logic [AW-1:0]    s1_a0_q, s1_a1_q;
  logic             s1_l_q, s1_r_q, s1_u_q, s1_d_q;
  logic [PIX_W-1:0] raw_rd_q;
  logic [PIX_W-1:0] raw_rd1_q;
  cls_e             cls_rd0_q, cls_rd1_q;
  logic [PIX_W-1:0] cr_q, lc_q, ll_q;
  cls_e             ul_q, left_q;
  logic             fw_valid_q;
  logic [AW-1:0]    fw_addr_q;
  cls_e             fw_data_q;

  logic [OCW-1:0]   out_cnt;
  logic             out_ready_unused;
  logic             s1_push;
  logic             single_row;
  logic [PIX_W-1:0] cv, rv;
  cls_e             uc, ur, kc, k;
  cls_e             n [8];
  logic [7:0]       nz, on;
  res_t             res, res_out;

  // hold issue while the output queue could overflow
  assign op_ready_o = ({1'b0, out_cnt} + (OCW+1)'(s1_valid_q && s1_emit_q))
                      < (OCW+1)'(OUT_DEPTH);
  assign issue      = op_valid_i && op_ready_o;

  assign e_l = ecol_q != '0;
  assign e_r = (ecol_q + 11'd1) < cfg_i.width;
  assign e_u = erow_q != '0;
  assign e_d = ({1'b0, erow_q} + 13'd1) < cfg_i.height;

  // advance push column and emit position; the frame's last pixel rewinds the push column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcol_q <= '0;
      ecol_q <= '0;
      erow_q <= '0;
    end else if (restart_i) begin
      pcol_q <= '0;
      ecol_q <= '0;
      erow_q <= '0;
    end else if (issue) begin
      pcol_q <= ((op_i.emit && !e_r && !e_d) || ((pcol_q + 11'd1) >= cfg_i.width))
                ? '0 : pcol_q + 11'd1;
      if (op_i.emit) begin
        if (!e_r) begin
          ecol_q <= '0;
          erow_q <= e_d ? erow_q + 1'b1 : '0;
        end else begin
          ecol_q <= ecol_q + 11'd1;
        end
      end
    end
  end

  // read line memories at issue, write the class back at the window stage
  always_ff @(posedge clk_i) begin
    if (issue) begin
      raw_rd_q              <= raw_mem[AW'(pcol_q)];
      raw_rd1_q             <= raw_mem[AW'(pcol_q + 11'd1)];
      raw_mem[AW'(pcol_q)]  <= op_i.value;
      cls_rd0_q             <= cls_mem[AW'(ecol_q)];
      cls_rd1_q             <= cls_mem[AW'(ecol_q + 11'd1)];
    end
    if (s1_push) cls_mem[s1_a0_q] <= k;
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fw_valid_q <= 1'b0;
      left_q     <= CLS_OFF;
    end else begin
      s1_valid_q <= issue;
      fw_valid_q <= s1_push;
      if (s1_push) left_q <= k;
    end
  end

  // window-stage payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_emit_q  <= op_i.emit;
      s1_value_q <= op_i.value;
      s1_a0_q    <= AW'(ecol_q);
      s1_a1_q    <= AW'(ecol_q + 11'd1);
      s1_l_q     <= e_l;
      s1_r_q     <= e_r;
      s1_u_q     <= e_u;
      s1_d_q     <= e_d;
    end
    if (s1_valid_q) begin
      cr_q <= raw_rd_q;
      lc_q <= s1_value_q;
      ll_q <= lc_q;
    end
    if (s1_push) ul_q <= uc;
    fw_addr_q <= s1_a0_q;
    fw_data_q <= k;
  end

  assign s1_push = s1_valid_q && s1_emit_q;

  // a one-row frame drains straight from the line memory at the emit column
  assign single_row = cfg_i.height == FH_W'(1);
  assign cv         = single_row ? raw_rd_q : cr_q;
  assign rv         = single_row ? raw_rd1_q : raw_rd_q;

  // forward the class written back in the previous cycle
  assign uc = (fw_valid_q && fw_addr_q == s1_a0_q) ? fw_data_q : cls_rd0_q;
  assign ur = (fw_valid_q && fw_addr_q == s1_a1_q) ? fw_data_q : cls_rd1_q;

  // build the neighbourhood and apply the erosion rule
  always_comb begin
    n[0] = s1_l_q ? left_q : CLS_OFF;
    n[1] = (s1_u_q && s1_l_q) ? ul_q : CLS_OFF;
    n[2] = s1_u_q ? uc : CLS_OFF;
    n[3] = (s1_u_q && s1_r_q) ? ur : CLS_OFF;
    n[4] = s1_r_q ? class_of(rv) : CLS_OFF;
    n[5] = (s1_d_q && s1_r_q) ? class_of(s1_value_q) : CLS_OFF;
    n[6] = s1_d_q ? class_of(lc_q) : CLS_OFF;
    n[7] = (s1_d_q && s1_l_q) ? class_of(ll_q) : CLS_OFF;
    for (int j = 0; j < 8; j++) begin
      nz[j] = n[j] != CLS_OFF;
      on[j] = n[j] == CLS_ON;
    end
    kc = class_of(cv);
    k  = (kc != CLS_OFF && erodes(nz, on, cfg_i.prune)) ? CLS_ERODED : kc;
    res.out_value    = (k == CLS_ON) ? cv : '0;
    res.end_of_row   = !s1_r_q;
    res.end_of_frame = !s1_r_q && !s1_d_q;
  end

  bstp_fifo #(
    .W     (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s1_push),
    .push_data_i  (res),
    .push_ready_o (out_ready_unused),
    .pop_valid_o  (res_o.valid),
    .pop_data_o   (res_out),
    .pop_ready_i  (res_o.ready),
    .count_o      (out_cnt)
  );

  assign res_o.out_value    = res_out.out_value;
  assign res_o.end_of_row   = res_out.end_of_row;
  assign res_o.end_of_frame = res_out.end_of_frame || (out_ready_unused && 1'b0);

endmodule

FILE: rtl/binary_skeleton_thinning_pass_core.sv
// ----------------------------------------------------------------------------
// binary_skeleton_thinning_pass_core: one streamed thinning pass
//
//   channel  dir  handshake      beat
//   pix_i    in   valid/ready    mode, pixel_value
//   res_o    out  valid/ready    out_value, end_of_row, end_of_frame
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// One beat per clock sustained while neither side stalls. A result leaves
// after its beat passes op queue, issue, window stage and output queue.
// Results trail input by one row plus one pixel; drain beats flush the tail.
// Reset clears positions and queues; line memories are not cleared.
// Either side may stall; a four-entry output queue decouples the window
// pipeline, and a four-entry op queue sits between intake and window engine.
// ----------------------------------------------------------------------------
module binary_skeleton_thinning_pass_core import bstp_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bstp_in_if.sink               pix_i,
  bstp_out_if.source            res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  localparam int WIDTH_CLAMP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
  localparam int WIDTH_INIT  = (WIDTH_CLAMP > 1024) ? 1024 : WIDTH_CLAMP;
  localparam logic [FW_W-1:0] WIDTH_LIMIT = FW_W'(WIDTH_CLAMP);
  localparam logic [FW_W-1:0] WIDTH_RESET = FW_W'(WIDTH_INIT);

  cfg_t            cfg_q;
  logic            restart;
  logic [FW_W-1:0] w_raw;
  logic [FH_W-1:0] h_raw;
  op_t             fr_op, q_op;
  logic            fr_valid, fr_ready;
  logic            q_valid, q_ready;
  logic [2:0]      q_cnt;

  assign w_raw = cfg_data_i[FW_W-1:0];
  assign h_raw = cfg_data_i[FH_W-1:0];
  assign restart = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_FRAME_WIDTH ||
                                cfg_idx_e'(cfg_idx_i) == CFG_FRAME_HEIGHT);

  // configuration registers with range clamps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= WIDTH_RESET;
      cfg_q.height <= HEIGHT_RESET;
      cfg_q.prune  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH: begin
          if (w_raw == '0) cfg_q.width <= FW_W'(1);
          else if (w_raw > WIDTH_LIMIT) cfg_q.width <= WIDTH_LIMIT;
          else cfg_q.width <= w_raw;
        end
        CFG_FRAME_HEIGHT: begin
          if (h_raw == '0) cfg_q.height <= FH_W'(1);
          else if (h_raw > HEIGHT_LIMIT) cfg_q.height <= HEIGHT_LIMIT;
          else cfg_q.height <= h_raw;
        end
        CFG_PRUNE_LEVEL: begin
          cfg_q.prune <= cfg_data_i[PR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  bstp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .restart_i  (restart),
    .pix_i      (pix_i),
    .op_o       (fr_op),
    .op_valid_o (fr_valid),
    .op_ready_i (fr_ready)
  );

  bstp_fifo #(
    .W     (OP_W),
    .DEPTH (4)
  ) u_op_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_data_i  (fr_op),
    .push_ready_o (fr_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_op),
    .pop_ready_i  (q_ready),
    .count_o      (q_cnt)
  );

  bstp_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .restart_i  (restart),
    .op_i       (q_op),
    .op_valid_i (q_valid && (q_cnt != '0)),
    .op_ready_o (q_ready),
    .res_o      (res_o)
  );

endmodule
